// File: hw/rtl/xml_escape_stream_core_defines.svh
// ----------------------------------------------------------------------------
// XML escape stream assertion macros
// Shared concurrent assertion forms for the escape stream modules.
// ----------------------------------------------------------------------------
`ifndef XML_ESCAPE_STREAM_CORE_DEFINES_SVH
`define XML_ESCAPE_STREAM_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define XES_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define XES_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/xes_pkg.sv
// ----------------------------------------------------------------------------
// XML escape stream package
// Payload types, command format, character codes and the entity string table.
// ----------------------------------------------------------------------------
package xes_pkg;

    localparam logic ACTION_STRING = 1'b0;
    localparam logic ACTION_START  = 1'b1;

    localparam logic [1:0] MODE_TEXT  = 2'd0;
    localparam logic [1:0] MODE_ATTR  = 2'd1;
    localparam logic [1:0] MODE_CDATA = 2'd2;

    localparam logic REG_DOC_CAPACITY = 1'b0;

    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_QUOT   = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    // Strings are left aligned in a 15-byte field; byte 0 sits at the top.
    localparam logic [119:0] STR_AMP    = {"&amp;", 80'h0};
    localparam logic [119:0] STR_LT     = {"&lt;", 88'h0};
    localparam logic [119:0] STR_GT     = {"&gt;", 88'h0};
    localparam logic [119:0] STR_QUOT   = {"&quot;", 72'h0};
    localparam logic [119:0] STR_APOS   = {"&#39;", 80'h0};
    localparam logic [119:0] STR_PREFIX = {"<![CDATA[", 48'h0};
    localparam logic [119:0] STR_SPLIT  = "]]]]><![CDATA[>";
    localparam logic [119:0] STR_SUFFIX = {"]]>", 96'h0};

    typedef struct packed {
        logic       action;
        logic [7:0] in_byte;
        logic       in_byte_valid;
        logic [1:0] escape_mode;
        logic       first_of_string;
        logic       last_of_string;
    } item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_valid;
        logic        end_of_run;
        logic        overflowed;
        logic [16:0] bytes_used;
    } result_t;

    typedef enum logic [3:0] {
        UK_NONE,
        UK_RAW,
        UK_BRACKET,
        UK_AMP,
        UK_LT,
        UK_GT,
        UK_QUOT,
        UK_APOS,
        UK_SPLIT,
        UK_PREFIX,
        UK_SUFFIX
    } unit_kind_t;

    // One classified item as handed from the front end to the back end.
    typedef struct packed {
        logic       clear;
        logic       prefix;
        logic [1:0] brackets;
        unit_kind_t main_kind;
        logic [7:0] raw_byte;
        logic       suffix;
        logic       status;
    } cmd_t;

    function automatic logic [3:0] uk_len(unit_kind_t k);
        logic [3:0] n;
        case (k)
            UK_RAW:     n = 4'd1;
            UK_BRACKET: n = 4'd1;
            UK_AMP:     n = 4'd5;
            UK_LT:      n = 4'd4;
            UK_GT:      n = 4'd4;
            UK_QUOT:    n = 4'd6;
            UK_APOS:    n = 4'd5;
            UK_SPLIT:   n = 4'd15;
            UK_PREFIX:  n = 4'd9;
            UK_SUFFIX:  n = 4'd3;
            default:    n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] uk_char(unit_kind_t k, logic [3:0] i, logic [7:0] raw);
        logic [119:0] s;
        logic [7:0]   r;
        case (k)
            UK_AMP:    s = STR_AMP;
            UK_LT:     s = STR_LT;
            UK_GT:     s = STR_GT;
            UK_QUOT:   s = STR_QUOT;
            UK_APOS:   s = STR_APOS;
            UK_SPLIT:  s = STR_SPLIT;
            UK_PREFIX: s = STR_PREFIX;
            UK_SUFFIX: s = STR_SUFFIX;
            default:   s = '0;
        endcase
        if (k == UK_RAW) begin
            r = raw;
        end else if (k == UK_BRACKET) begin
            r = CH_RBRACK;
        end else if (i > 4'd14) begin
            r = '0;
        end else begin
            r = s[119 - 8 * int'(i) -: 8];
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/xes_fifo.sv
// ----------------------------------------------------------------------------
// XML escape stream queue
// Small register queue with combinational head read and same-cycle push/pop.
// ----------------------------------------------------------------------------
module xes_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: hw/rtl/xes_front.sv
// ----------------------------------------------------------------------------
// XML escape stream front end
// Accepts input items, tracks held CDATA brackets and builds unit commands.
// ----------------------------------------------------------------------------
module xes_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  xes_pkg::item_t item,
    output logic           full,
    input  logic           cmd_full,
    output logic           cmd_push,
    output xes_pkg::cmd_t  cmd_wdata
);

    import xes_pkg::*;

    logic [1:0] held_reg, held_next;
    logic       accept;
    logic       present;
    logic [1:0] mode;
    logic       cdata;
    logic       attr;
    logic [1:0] held_start;
    logic [1:0] held_after;
    cmd_t       cmd;

    assign full   = cmd_full;
    assign accept = push && !cmd_full;

    always_comb
    begin
        mode       = (item.escape_mode == MODE_CDATA || item.escape_mode == MODE_ATTR)
                     ? item.escape_mode : MODE_TEXT;
        cdata      = (mode == MODE_CDATA);
        attr       = (mode == MODE_ATTR);
        // A new string drops brackets left over from an unfinished one.
        held_start = item.first_of_string ? 2'd0 : held_reg;
        held_after = held_start;
        cmd        = '0;
        cmd.main_kind = UK_NONE;
        cmd.raw_byte  = item.in_byte;

        if (item.action == ACTION_START)
        begin
            cmd.clear  = 1'b1;
            cmd.status = 1'b1;
            held_after = 2'd0;
        end else
        begin
            cmd.prefix = item.first_of_string && cdata;
            if (item.in_byte_valid)
            begin
                if (cdata)
                begin
                    if (item.in_byte == CH_RBRACK)
                    begin
                        if (held_start < 2'd2)
                        begin
                            held_after = held_start + 2'd1;
                        end else
                        begin
                            cmd.main_kind = UK_RAW;
                        end
                    end else if (item.in_byte == CH_GT && held_start == 2'd2)
                    begin
                        held_after    = 2'd0;
                        cmd.main_kind = UK_SPLIT;
                    end else
                    begin
                        cmd.brackets  = held_start;
                        held_after    = 2'd0;
                        cmd.main_kind = UK_RAW;
                    end
                end else
                begin
                    cmd.brackets = held_start;
                    held_after   = 2'd0;
                    if (item.in_byte == CH_AMP)
                    begin
                        cmd.main_kind = UK_AMP;
                    end else if (item.in_byte == CH_LT)
                    begin
                        cmd.main_kind = UK_LT;
                    end else if (item.in_byte == CH_GT)
                    begin
                        cmd.main_kind = UK_GT;
                    end else if (attr && item.in_byte == CH_QUOT)
                    begin
                        cmd.main_kind = UK_QUOT;
                    end else if (attr && item.in_byte == CH_APOS)
                    begin
                        cmd.main_kind = UK_APOS;
                    end else
                    begin
                        cmd.main_kind = UK_RAW;
                    end
                end
            end
            if (item.last_of_string)
            begin
                // Every bracket unit is a lone ']', so the end-of-string flush
                // merges with any flush ahead of the byte.
                cmd.brackets = cmd.brackets + held_after;
                held_after   = 2'd0;
                cmd.suffix   = cdata;
                cmd.status   = 1'b1;
            end
        end
        held_next = accept ? held_after : held_reg;
        present   = cmd.prefix || (cmd.brackets != 2'd0) || (cmd.main_kind != UK_NONE)
                    || cmd.suffix || cmd.status;
    end

    assign cmd_push  = accept && present;
    assign cmd_wdata = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 2'd0;
        end else
        begin
            held_reg <= held_next;
        end
    end

endmodule

// File: hw/rtl/xes_back.sv
// ----------------------------------------------------------------------------
// XML escape stream back end
// Walks the units of each command, checks capacity and emits result bytes.
// ----------------------------------------------------------------------------
`include "xml_escape_stream_core_defines.svh"

module xes_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [16:0]      cap,
    input  logic             cmd_empty,
    input  xes_pkg::cmd_t    cmd,
    output logic             cmd_pop,
    input  logic             res_full,
    output logic             res_push,
    output xes_pkg::result_t res_wdata
);

    import xes_pkg::*;

    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_BRACKET,
        PH_MAIN,
        PH_SUFFIX,
        PH_STATUS,
        PH_NONE
    } phase_t;

    function automatic phase_t first_from(cmd_t c, phase_t p);
        phase_t r;
        r = PH_NONE;
        if (p <= PH_STATUS && c.status) r = PH_STATUS;
        if (p <= PH_SUFFIX && c.suffix) r = PH_SUFFIX;
        if (p <= PH_MAIN && c.main_kind != UK_NONE) r = PH_MAIN;
        if (p <= PH_BRACKET && c.brackets != 2'd0) r = PH_BRACKET;
        if (p <= PH_PREFIX && c.prefix) r = PH_PREFIX;
        return r;
    endfunction

    function automatic unit_kind_t phase_kind(cmd_t c, phase_t p);
        unit_kind_t k;
        case (p)
            PH_PREFIX:  k = UK_PREFIX;
            PH_BRACKET: k = UK_BRACKET;
            PH_MAIN:    k = c.main_kind;
            PH_SUFFIX:  k = UK_SUFFIX;
            default:    k = UK_NONE;
        endcase
        return k;
    endfunction

    phase_t      phase_reg, phase_next;
    logic [1:0]  brk_reg, brk_next;
    logic [3:0]  idx_reg, idx_next;
    logic        busy_reg, busy_next;
    logic [16:0] used_reg, used_next;
    logic        ovf_reg, ovf_next;

    logic        step;
    phase_t      ph, ph_plus, np;
    logic [1:0]  brk;
    logic [3:0]  idx;
    unit_kind_t  kind;
    logic [3:0]  len, nlen;
    logic [16:0] used_inc;
    logic        fits, next_fits;
    logic        is_status, is_unit;
    logic        emit, fail, last_byte, more_brk, end_byte, unit_done;

    always_comb
    begin
        step      = !cmd_empty && !res_full;
        ph        = busy_reg ? phase_reg : first_from(cmd, PH_PREFIX);
        brk       = busy_reg ? brk_reg : cmd.brackets;
        idx       = busy_reg ? idx_reg : 4'd0;
        kind      = phase_kind(cmd, ph);
        len       = uk_len(kind);
        used_inc  = used_reg + 17'd1;
        is_status = (ph == PH_STATUS);
        is_unit   = !is_status && (ph != PH_NONE);
        // A unit goes out whole or not at all; the check is made on its first byte.
        fits      = !ovf_reg && ({1'b0, used_reg} + 18'(len) <= {1'b0, cap});
        emit      = is_unit && (idx != 4'd0 || fits);
        fail      = is_unit && idx == 4'd0 && !fits;
        last_byte = (idx == len - 4'd1);

        more_brk  = (ph == PH_BRACKET) && (brk > 2'd1);
        ph_plus   = (ph == PH_NONE) ? PH_NONE : phase_t'(ph + 3'd1);
        np        = more_brk ? PH_BRACKET : first_from(cmd, ph_plus);
        nlen      = more_brk ? 4'd1 : uk_len(phase_kind(cmd, np));
        next_fits = ({1'b0, used_inc} + 18'(nlen) <= {1'b0, cap});
        // The last byte closes the run unless a status follows or the next unit fits.
        end_byte  = !cmd.status && (np == PH_NONE || !next_fits);
        unit_done = is_status || fail || (emit && last_byte) || (ph == PH_NONE);

        res_push  = step && (is_status || emit);
        res_wdata = '0;
        if (is_status)
        begin
            res_wdata.out_byte   = 8'd0;
            res_wdata.out_valid  = 1'b0;
            res_wdata.end_of_run = 1'b1;
            res_wdata.overflowed = cmd.clear ? 1'b0 : ovf_reg;
            res_wdata.bytes_used = cmd.clear ? 17'd0 : used_reg;
        end else
        begin
            res_wdata.out_byte   = uk_char(kind, idx, cmd.raw_byte);
            res_wdata.out_valid  = 1'b1;
            res_wdata.end_of_run = last_byte && end_byte;
            res_wdata.overflowed = ovf_reg;
            res_wdata.bytes_used = used_inc;
        end

        phase_next = phase_reg;
        brk_next   = brk_reg;
        idx_next   = idx_reg;
        busy_next  = busy_reg;
        used_next  = used_reg;
        ovf_next   = ovf_reg;
        cmd_pop    = 1'b0;
        if (step)
        begin
            if (is_status && cmd.clear)
            begin
                used_next = 17'd0;
                ovf_next  = 1'b0;
            end
            if (emit)
            begin
                used_next = used_inc;
            end
            if (fail)
            begin
                ovf_next = 1'b1;
            end
            if (!unit_done)
            begin
                phase_next = ph;
                brk_next   = brk;
                idx_next   = idx + 4'd1;
                busy_next  = 1'b1;
            end else if (more_brk)
            begin
                phase_next = PH_BRACKET;
                brk_next   = brk - 2'd1;
                idx_next   = 4'd0;
                busy_next  = 1'b1;
            end else if (np == PH_NONE)
            begin
                cmd_pop   = 1'b1;
                busy_next = 1'b0;
                idx_next  = 4'd0;
            end else
            begin
                phase_next = np;
                brk_next   = brk;
                idx_next   = 4'd0;
                busy_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PREFIX;
            brk_reg   <= 2'd0;
            idx_reg   <= 4'd0;
            busy_reg  <= 1'b0;
            used_reg  <= 17'd0;
            ovf_reg   <= 1'b0;
        end else
        begin
            phase_reg <= phase_next;
            brk_reg   <= brk_next;
            idx_reg   <= idx_next;
            busy_reg  <= busy_next;
            used_reg  <= used_next;
            ovf_reg   <= ovf_next;
        end
    end

    `XES_ASSERT_IMP(a_byte_needs_room, clk, rst_n, res_push && res_wdata.out_valid, !ovf_reg, "document byte emitted while overflowed")
    `XES_ASSERT_NXT(a_used_counts_bytes, clk, rst_n, step && emit, used_reg == $past(used_inc), "byte count did not advance with an emitted byte")
    `XES_ASSERT_NXT(a_overflow_sticky, clk, rst_n, ovf_reg && !(step && is_status && cmd.clear), ovf_reg, "overflow flag dropped without a new document")
    `XES_ASSERT_IMP(a_status_closes_cmd, clk, rst_n, cmd_pop && cmd.status, ph == PH_STATUS, "command with a status retired before its status result")

endmodule

// File: hw/rtl/xml_escape_stream_core.sv
// ----------------------------------------------------------------------------
// XML escape stream core
// Streaming XML entity and CDATA escaper writing into a bounded document.
// ----------------------------------------------------------------------------
// Text bytes enter one transaction at a time and leave as escaped document
// bytes plus one status result after each string end or document start. An
// item that yields at most one result, such as a plain text byte, streams
// back to back with the next such item while the result queue has room. An
// item that expands into several results (an entity, the CDATA prefix, split
// sequence or suffix, released brackets, or a closing status) is walked unit
// by unit by the back-end sequencer, which emits one result per cycle while
// the result queue has room, but none for a unit turned away for lack of
// room. While it works, the input queue keeps absorbing items until it
// fills, and full then holds off push.
// ----------------------------------------------------------------------------
module xml_escape_stream_core #(
    parameter int MAX_DOC_BYTES = 65536,
    parameter int CMD_DEPTH     = 4,
    parameter int RES_DEPTH     = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    // Input queue side: a transaction is accepted when push is high and full is low.
    input  logic             push,
    output logic             full,
    input  xes_pkg::item_t   item,
    // Result queue side: a transaction is accepted when pop is high and empty is low.
    output logic             empty,
    input  logic             pop,
    output xes_pkg::result_t result,
    // Configuration port.
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    import xes_pkg::*;

    localparam int CMD_W = $bits(cmd_t);
    localparam int RES_W = $bits(result_t);

    // Reset capacity is 64 KiB, limited by the document maximum.
    localparam logic [16:0] CAP_RESET = (MAX_DOC_BYTES < 65536) ? 17'(MAX_DOC_BYTES) : 17'd65536;
    localparam logic [16:0] CAP_SAT   = (MAX_DOC_BYTES > 131071) ? 17'h1FFFF
                                                                 : 17'(MAX_DOC_BYTES);

    logic [16:0]      cap_reg, cap_next;
    logic             cfg_write;
    logic [16:0]      wr_value;

    logic             cmd_push, cmd_full, cmd_empty, cmd_pop;
    cmd_t             cmd_wdata, cmd_head;
    logic [CMD_W-1:0] cmd_rdata;

    logic             res_push, res_full;
    result_t          res_wdata;
    logic [RES_W-1:0] res_rdata;

    // The configuration port never waits. Writes land on the access phase, and
    // the written capacity is clipped to the document maximum.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_DOC_CAPACITY);
    assign wr_value  = pwdata[16:0];
    assign prdata    = (paddr[2] == REG_DOC_CAPACITY) ? {15'd0, cap_reg} : 32'd0;

    always_comb
    begin
        cap_next = cap_reg;
        if (cfg_write)
        begin
            cap_next = ({15'd0, wr_value} > 32'(MAX_DOC_BYTES)) ? CAP_SAT : wr_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end else
        begin
            cap_reg <= cap_next;
        end
    end

    // The front end classifies each item into a command of output units and
    // keeps the count of CDATA brackets held back for the next byte.
    xes_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .cmd_full  (cmd_full),
        .cmd_push  (cmd_push),
        .cmd_wdata (cmd_wdata)
    );

    // Commands wait here, so the input side keeps moving during expansions.
    xes_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_wdata),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_rdata),
        .empty (cmd_empty)
    );

    assign cmd_head = cmd_t'(cmd_rdata);

    // The back end owns the byte count and the sticky overflow flag, and produces
    // one result per cycle while a command waits, the result queue has room and no unit is refused.
    xes_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap       (cap_reg),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_head),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_wdata (res_wdata)
    );

    // Results queue up here, so a stalled consumer does not stop the back end
    // until the queue is full.
    xes_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wdata),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign result = result_t'(res_rdata);

endmodule
